### rtl/core/shpb_pkg.sv
package shpb_pkg;

   // One in Q1.16 and the rounding half for a shift by 16.
   localparam logic [16:0] HS_ONE   = 17'd65536;
   localparam logic [16:0] HS_HALF  = 17'd32768;

   // Pipeline shape.
   localparam int NUM_STAGES    = 12;
   localparam int HORNER_STEPS  = 4;

   // Odd polynomial for sin(pi*u)/(2*pi), coefficients in Q30.
   localparam logic [29:0] C9_Q30 = 30'd14038015;
   localparam logic [29:0] HORNER_COEF [HORNER_STEPS] = '{
      30'd102409106,   // u^7 term
      30'd435800896,   // u^5 term
      30'd883117253,   // u^3 term
      30'd536870912    // u^1 term
   };

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CFG_BAND_HALF_WIDTH   = 3'd0,
      CFG_BAND_INVERSE      = 3'd1,
      CFG_DENSITY_INSIDE    = 3'd2,
      CFG_DENSITY_OUTSIDE   = 3'd3,
      CFG_VISCOSITY_INSIDE  = 3'd4,
      CFG_VISCOSITY_OUTSIDE = 3'd5
   } cfg_index_type;

   // Where the sample lies relative to the interface band.
   typedef enum logic [1:0] {
      REGION_BAND  = 2'd0,
      REGION_ABOVE = 2'd1,
      REGION_BELOW = 2'd2
   } region_type;

   typedef struct packed {
      region_type region;
      logic       neg;
   } ctl_type;

endpackage

### rtl/core/smoothed_heaviside_property_blend.sv
// Smoothed Heaviside property blend. Each transaction on the req_ channel carries one
// signed Q16.16 level-set sample; the block returns one transaction on the rsp_
// channel with the smoothed Heaviside value H (unsigned Q1.16, 65536 means one) and
// the density and viscosity blended as outside + H*(inside - outside), rounded and
// saturated to unsigned Q16.16. The block is a twelve-stage pipeline that accepts
// one transaction per clock while the output is not stalled; the depth is set by
// the chain of multiplications (scale by the band reciprocal, square, four Horner
// steps of the sine polynomial, final product, blend), each followed by a register.
// A stall on rsp_stall while a result is waiting at the output freezes the whole
// pipeline and is passed back on req_stall in the same cycle, so nothing is lost
// or repeated. The six configuration registers are written through
// csr_write/csr_index/csr_data and reset to 1.0; they may only be changed while no
// transaction is in flight. Writes to unknown indexes are ignored.
module smoothed_heaviside_property_blend (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_level_value,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_heaviside_value,
   output logic [31:0] rsp_density_value,
   output logic [31:0] rsp_viscosity_value,
   // Configuration write port.
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int LAST = shpb_pkg::NUM_STAGES - 1;

   // Configuration registers.
   logic [30:0] band_half_width_ff;
   logic [30:0] band_inverse_ff;
   logic [31:0] density_inside_ff;
   logic [31:0] density_outside_ff;
   logic [31:0] viscosity_inside_ff;
   logic [31:0] viscosity_outside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_half_width_ff   <= 31'(shpb_pkg::HS_ONE);
         band_inverse_ff      <= 31'(shpb_pkg::HS_ONE);
         density_inside_ff    <= 32'(shpb_pkg::HS_ONE);
         density_outside_ff   <= 32'(shpb_pkg::HS_ONE);
         viscosity_inside_ff  <= 32'(shpb_pkg::HS_ONE);
         viscosity_outside_ff <= 32'(shpb_pkg::HS_ONE);
      end else if (csr_write) begin
         case (shpb_pkg::cfg_index_type'(csr_index))
            shpb_pkg::CFG_BAND_HALF_WIDTH:   band_half_width_ff   <= csr_data[30:0];
            shpb_pkg::CFG_BAND_INVERSE:      band_inverse_ff      <= csr_data[30:0];
            shpb_pkg::CFG_DENSITY_INSIDE:    density_inside_ff    <= csr_data;
            shpb_pkg::CFG_DENSITY_OUTSIDE:   density_outside_ff   <= csr_data;
            shpb_pkg::CFG_VISCOSITY_INSIDE:  viscosity_inside_ff  <= csr_data;
            shpb_pkg::CFG_VISCOSITY_OUTSIDE: viscosity_outside_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves as a whole whenever the output register is free or drained.
   logic                          advance;
   logic [shpb_pkg::NUM_STAGES-1:0] vld_ff;

   assign advance   = !vld_ff[LAST] || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid};
      end
   end

   // Stage 1: classify the sample against the band and take its magnitude.
   logic [32:0]       phi_ext;
   logic [32:0]       eps_ext;
   shpb_pkg::ctl_type ctl_in;
   logic [31:0]       mag_in;
   shpb_pkg::ctl_type ctl_ff [0:8];
   logic [31:0]       mag_ff;

   always_comb begin
      phi_ext    = {req_level_value[31], req_level_value};
      eps_ext    = {2'b00, band_half_width_ff};
      ctl_in.neg = req_level_value[31];
      if ($signed(phi_ext) > $signed(eps_ext)) begin
         ctl_in.region = shpb_pkg::REGION_ABOVE;
      end else if ($signed(phi_ext) <= -$signed(eps_ext)) begin
         ctl_in.region = shpb_pkg::REGION_BELOW;
      end else begin
         ctl_in.region = shpb_pkg::REGION_BAND;
      end
      mag_in = req_level_value[31] ? (~req_level_value + 32'd1) : req_level_value;
   end

   // Stage 2: scale the magnitude by the band reciprocal.
   logic [62:0] prod_in;
   logic [62:0] prod_ff;

   assign prod_in = 63'(mag_ff) * 63'(band_inverse_ff);

   // Stage 3: round to Q16, saturate at one and fold around one half.
   logic [63:0] prod_rnd;
   logic [47:0] prod_sh;
   logic [16:0] a_in;
   logic [16:0] fold;
   logic [15:0] u_in;
   logic [16:0] a_ff [2:8];
   logic [15:0] u_ff [2:7];

   always_comb begin
      prod_rnd = {1'b0, prod_ff} + 64'(shpb_pkg::HS_HALF);
      prod_sh  = prod_rnd[63:16];
      a_in     = (prod_sh > 48'(shpb_pkg::HS_ONE)) ? shpb_pkg::HS_ONE : prod_sh[16:0];
      fold     = (a_in > shpb_pkg::HS_HALF) ? (shpb_pkg::HS_ONE - a_in) : a_in;
      u_in     = fold[15:0];
   end

   // Stage 4: v = u*u in Q30.
   logic [31:0] sq;
   logic [28:0] v_in;
   logic [28:0] v_ff [3:6];

   assign sq   = 32'(u_ff[2]) * 32'(u_ff[2]);
   assign v_in = sq[30:2];

   // Stages 5 to 8: one Horner step each.
   logic [29:0] p_src  [4:7];
   logic [58:0] h_prod [4:7];
   logic [29:0] p_in   [4:7];
   logic [29:0] p_ff   [4:7];

   always_comb begin
      p_src[4] = shpb_pkg::C9_Q30;
      for (int k = 5; k <= 7; k++) begin
         p_src[k] = p_ff[k-1];
      end
      for (int k = 4; k <= 7; k++) begin
         h_prod[k] = 59'(p_src[k]) * 59'(v_ff[k-1]);
         p_in[k]   = shpb_pkg::HORNER_COEF[k-4] - {1'b0, h_prod[k][58:30]};
      end
   end

   // Stage 9: p*u.
   logic [45:0] pu_in;
   logic [45:0] pu_ff;

   assign pu_in = 46'(p_ff[7]) * 46'(u_ff[7]);

   // Stage 10: finish the sine term and form H.
   logic [46:0] g_sum;
   logic [17:0] g;
   logic [18:0] hp_sum;
   logic [17:0] hp;
   logic [16:0] hp_lim;
   logic [16:0] h_in;
   logic [16:0] h_ff [9:10];

   always_comb begin
      g_sum  = {1'b0, pu_ff} + (47'd1 << 28);
      g      = g_sum[46:29];
      hp_sum = 19'(shpb_pkg::HS_ONE) + 19'(a_ff[8]) + 19'(g) + 19'd1;
      hp     = hp_sum[18:1];
      hp_lim = (hp > 18'(shpb_pkg::HS_ONE)) ? shpb_pkg::HS_ONE : hp[16:0];
      case (ctl_ff[8].region)
         shpb_pkg::REGION_ABOVE: h_in = shpb_pkg::HS_ONE;
         shpb_pkg::REGION_BELOW: h_in = '0;
         default: h_in = ctl_ff[8].neg ? (shpb_pkg::HS_ONE - hp_lim) : hp_lim;
      endcase
   end

   // Stage 11: blend products.
   logic [16:0] h_comp;
   logic [48:0] den_out_in, den_in_in, vis_out_in, vis_in_in;
   logic [48:0] den_out_ff, den_in_ff, vis_out_ff, vis_in_ff;

   always_comb begin
      h_comp     = shpb_pkg::HS_ONE - h_ff[9];
      den_out_in = 49'(density_outside_ff) * 49'(h_comp);
      den_in_in  = 49'(density_inside_ff) * 49'(h_ff[9]);
      vis_out_in = 49'(viscosity_outside_ff) * 49'(h_comp);
      vis_in_in  = 49'(viscosity_inside_ff) * 49'(h_ff[9]);
   end

   // Stage 12: round, saturate and register the result.
   logic [49:0] den_sum, vis_sum;
   logic [31:0] den_in, vis_in;
   logic [16:0] heaviside_ff;
   logic [31:0] density_ff, viscosity_ff;

   always_comb begin
      den_sum = 50'(den_out_ff) + 50'(den_in_ff) + 50'(shpb_pkg::HS_HALF);
      vis_sum = 50'(vis_out_ff) + 50'(vis_in_ff) + 50'(shpb_pkg::HS_HALF);
      den_in  = (|den_sum[49:48]) ? '1 : den_sum[47:16];
      vis_in  = (|vis_sum[49:48]) ? '1 : vis_sum[47:16];
   end

   // Payload registers, all moving together with the valid bits.
   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i <= 8; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
         mag_ff  <= mag_in;
         prod_ff <= prod_in;
         a_ff[2] <= a_in;
         for (int i = 3; i <= 8; i++) begin
            a_ff[i] <= a_ff[i-1];
         end
         u_ff[2] <= u_in;
         for (int i = 3; i <= 7; i++) begin
            u_ff[i] <= u_ff[i-1];
         end
         v_ff[3] <= v_in;
         for (int i = 4; i <= 6; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
         for (int i = 4; i <= 7; i++) begin
            p_ff[i] <= p_in[i];
         end
         pu_ff        <= pu_in;
         h_ff[9]      <= h_in;
         h_ff[10]     <= h_ff[9];
         den_out_ff   <= den_out_in;
         den_in_ff    <= den_in_in;
         vis_out_ff   <= vis_out_in;
         vis_in_ff    <= vis_in_in;
         heaviside_ff <= h_ff[10];
         density_ff   <= den_in;
         viscosity_ff <= vis_in;
      end
   end

   assign rsp_valid           = vld_ff[LAST];
   assign rsp_heaviside_value = heaviside_ff;
   assign rsp_density_value   = density_ff;
   assign rsp_viscosity_value = viscosity_ff;

endmodule

### rtl/core/shpb_checker.sv
module shpb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_level_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_heaviside_value,
   input logic [31:0] rsp_density_value,
   input logic [31:0] rsp_viscosity_value,
   input logic        csr_write,
   input logic [2:0]  csr_index,
   input logic [31:0] csr_data
);

   // H never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heaviside_value <= shpb_pkg::HS_ONE)
      else $error("heaviside value above one");

   // The input is only held back when a finished result is waiting downstream.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_heaviside_value)
         && $stable(rsp_density_value) && $stable(rsp_viscosity_value)))
      else $error("stalled response changed");

endmodule

bind smoothed_heaviside_property_blend shpb_checker u_shpb_checker (.*);
